@@ hdl/eit_pkg.sv @@
package eit_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_MODIFY = 3'd2;
  localparam logic [2:0] OP_REPORT = 3'd3;
  localparam logic [2:0] OP_ROUND  = 3'd4;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_BAD_FD    = 3'd1;
  localparam logic [2:0] STATUS_EXISTS    = 3'd2;
  localparam logic [2:0] STATUS_NO_ENTRY  = 3'd3;
  localparam logic [2:0] STATUS_INVALID   = 3'd4;
  localparam logic [2:0] STATUS_NOT_ARMED = 3'd5;
  localparam logic [2:0] STATUS_FULL      = 3'd6;

  localparam int EV_EDGE_BIT    = 31;
  localparam int EV_ONESHOT_BIT = 30;
  localparam int EV_READ_BIT    = 0;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  fd;
    logic        fd_open;
    logic [31:0] event_mask;
    logic [63:0] user_data;
    logic [31:0] revents;
    logic        has_read_seq;
    logic [63:0] read_seq;
    logic [15:0] max_events;
  } eit_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        report_valid;
    logic [31:0] report_mask;
    logic [63:0] report_data;
    logic [63:0] change_count;
  } eit_result_t;

  typedef struct packed {
    logic present;
    logic armed;
  } eit_flags_t;

  typedef struct packed {
    logic [31:0] events;
    logic [63:0] data;
    logic [31:0] last_reported;
    logic [63:0] last_seq;
  } eit_entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        rep_valid;
    logic [31:0] rep_mask;
    logic [63:0] rep_data;
    logic        flag_we;
    eit_flags_t  flags;
    logic        entry_we;
    eit_entry_t  entry;
    logic        cnt_inc;
    logic        round_start;
    logic        round_inc;
  } eit_upd_t;

endpackage

@@ hdl/eit_flag_mem.sv @@
module eit_flag_mem #(
  parameter int TABLE_ENTRIES = eit_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 re,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]     raddr,
  output eit_pkg::eit_flags_t                  rdata,
  input  logic                                 we,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]     waddr,
  input  eit_pkg::eit_flags_t                  wdata,
  output logic                                 clearing
);
  import eit_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  eit_flags_t       mem [TABLE_ENTRIES];
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + IDX_W'(1);
      if (clr_idx == LAST_IDX) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/eit_entry_mem.sv @@
module eit_entry_mem #(
  parameter int TABLE_ENTRIES = eit_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             re,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
  output eit_pkg::eit_entry_t              rdata,
  input  logic                             we,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
  input  eit_pkg::eit_entry_t              wdata
);
  import eit_pkg::*;

  eit_entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/eit_exec.sv @@
module eit_exec (
  input  eit_pkg::eit_cmd_t   cmd,
  input  logic                inrange,
  input  eit_pkg::eit_flags_t flags,
  input  eit_pkg::eit_entry_t entry,
  input  logic [15:0]         round_delivered,
  input  logic [15:0]         round_limit,
  output eit_pkg::eit_upd_t   upd
);
  import eit_pkg::*;

  logic        edge_mode;
  logic [31:0] deliver;

  always_comb begin
    edge_mode = entry.events[EV_EDGE_BIT];
    deliver   = edge_mode ? (cmd.revents & ~entry.last_reported) : cmd.revents;
    if (edge_mode && cmd.revents[EV_READ_BIT] && cmd.has_read_seq &&
        (cmd.read_seq != entry.last_seq)) begin
      deliver[EV_READ_BIT] = 1'b1;
    end
  end

  always_comb begin
    upd             = '0;
    upd.status      = STATUS_OK;
    upd.flags       = flags;
    upd.entry       = entry;
    if (cmd.op == OP_REPORT) begin
      if (!inrange || !flags.present || !flags.armed) begin
        upd.status = STATUS_NOT_ARMED;
      end else if (round_delivered >= round_limit) begin
        upd.status = STATUS_FULL;
      end else begin
        if (edge_mode) begin
          upd.entry_we            = 1'b1;
          upd.entry.last_reported = cmd.revents;
          if (deliver[EV_READ_BIT] && cmd.has_read_seq) begin
            upd.entry.last_seq = cmd.read_seq;
          end
        end
        if (deliver != '0) begin
          upd.rep_valid = 1'b1;
          upd.rep_mask  = deliver;
          upd.rep_data  = entry.data;
          upd.round_inc = 1'b1;
          if (entry.events[EV_ONESHOT_BIT]) begin
            upd.flag_we     = 1'b1;
            upd.flags.armed = 1'b0;
          end
        end
      end
    end else if (cmd.op == OP_ROUND) begin
      upd.round_start = 1'b1;
    end else if (!cmd.fd_open || !inrange) begin
      upd.status = STATUS_BAD_FD;
    end else begin
      case (cmd.op)
        OP_ADD: begin
          if (flags.present) begin
            upd.status = STATUS_EXISTS;
          end else begin
            upd.flag_we             = 1'b1;
            upd.flags               = '{present: 1'b1, armed: 1'b1};
            upd.entry_we            = 1'b1;
            upd.entry.events        = cmd.event_mask;
            upd.entry.data          = cmd.user_data;
            upd.entry.last_reported = '0;
            upd.entry.last_seq      = '0;
            upd.cnt_inc             = 1'b1;
          end
        end
        OP_DELETE: begin
          if (!flags.present) begin
            upd.status = STATUS_NO_ENTRY;
          end else begin
            upd.flag_we = 1'b1;
            upd.flags   = '{present: 1'b0, armed: 1'b0};
            upd.cnt_inc = 1'b1;
          end
        end
        OP_MODIFY: begin
          if (!flags.present) begin
            upd.status = STATUS_NO_ENTRY;
          end else begin
            upd.flag_we             = 1'b1;
            upd.flags               = '{present: 1'b1, armed: 1'b1};
            upd.entry_we            = 1'b1;
            upd.entry.events        = cmd.event_mask;
            upd.entry.data          = cmd.user_data;
            upd.entry.last_reported = '0;
            upd.cnt_inc             = 1'b1;
          end
        end
        default: begin
          upd.status = STATUS_INVALID;
        end
      endcase
    end
  end

endmodule

@@ hdl/event_interest_table.sv @@
// Channel | Ports              | Handshake
// --------+--------------------+-----------------------------------------
// item in | start, busy, cmd   | taken at an edge with start high, busy low
// result  | done, result       | done high for one cycle, always taken
//
// The entry and flag memories are read at the edge that accepts an item; the
// entry is modified and written back as the EXEC state ends, and the result is
// registered at that same edge. Busy stays high in EXEC, so a new item can be
// accepted only after the result of the last one has been registered.
// After reset, busy stays high while every entry of the flag memory
// is swept clear. The receiver cannot stall the result.
module event_interest_table #(
  parameter int TABLE_ENTRIES = eit_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  eit_pkg::eit_cmd_t    cmd,
  output logic                 done,
  output eit_pkg::eit_result_t result
);
  import eit_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_EXEC = 1'b1;

  logic             state;
  logic             clearing;
  logic             accept;
  eit_cmd_t         item;
  logic [IDX_W-1:0] item_idx;
  logic             item_inrange;
  eit_flags_t       flags_rd;
  eit_entry_t       entry_rd;
  eit_upd_t         upd;
  logic [63:0]      change_counter;
  logic [63:0]      change_counter_next;
  logic [15:0]      round_delivered;
  logic [15:0]      round_limit;

  assign busy     = clearing || (state == STATE_EXEC);
  assign accept   = start && !busy;
  assign item_idx = IDX_W'(item.fd);
  assign item_inrange = 32'(item.fd) < 32'(TABLE_ENTRIES);
  assign change_counter_next = change_counter + 64'(upd.cnt_inc);

  eit_flag_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_flag_mem (
    .clk      (clk),
    .rst      (rst),
    .re       (accept),
    .raddr    (IDX_W'(cmd.fd)),
    .rdata    (flags_rd),
    .we       ((state == STATE_EXEC) && upd.flag_we),
    .waddr    (item_idx),
    .wdata    (upd.flags),
    .clearing (clearing)
  );

  eit_entry_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_entry_mem (
    .clk   (clk),
    .re    (accept),
    .raddr (IDX_W'(cmd.fd)),
    .rdata (entry_rd),
    .we    ((state == STATE_EXEC) && upd.entry_we),
    .waddr (item_idx),
    .wdata (upd.entry)
  );

  eit_exec u_exec (
    .cmd             (item),
    .inrange         (item_inrange),
    .flags           (flags_rd),
    .entry           (entry_rd),
    .round_delivered (round_delivered),
    .round_limit     (round_limit),
    .upd             (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= STATE_IDLE;
      done            <= 1'b0;
      change_counter  <= '0;
      round_delivered <= '0;
      round_limit     <= 16'd1;
    end else begin
      done <= (state == STATE_EXEC);
      case (state)
        STATE_IDLE: begin
          if (accept) begin
            state <= STATE_EXEC;
          end
        end
        STATE_EXEC: begin
          state          <= STATE_IDLE;
          change_counter <= change_counter_next;
          if (upd.round_start) begin
            round_limit     <= (item.max_events == '0) ? 16'd1 : item.max_events;
            round_delivered <= '0;
          end else if (upd.round_inc) begin
            round_delivered <= round_delivered + 16'd1;
          end
        end
        default: begin
          state <= STATE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd;
    end
    if (state == STATE_EXEC) begin
      result.status       <= upd.status;
      result.report_valid <= upd.rep_valid;
      result.report_mask  <= upd.rep_mask;
      result.report_data  <= upd.rep_data;
      result.change_count <= change_counter_next;
    end
  end

endmodule

@@ tb/tb_event_interest_table.sv @@
module tb_event_interest_table;
  timeunit 1ns;
  timeprecision 1ps;

  import eit_pkg::*;

  localparam int NUM_FDS = TABLE_ENTRIES_DEF;
  localparam int NUM_RANDOM = 1600;
  localparam int PHASE_ITEMS = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam logic [31:0] ET_FLAG = 32'h1 << EV_EDGE_BIT;
  localparam logic [31:0] ONESHOT_FLAG = 32'h1 << EV_ONESHOT_BIT;
  localparam logic [31:0] READ_FLAG = 32'h1 << EV_READ_BIT;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  eit_cmd_t cmd = '0;
  eit_result_t result;

  event_interest_table u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  eit_cmd_t cmd_backlog[$];
  eit_result_t pending_results[$];

  logic        tbl_present[NUM_FDS];
  logic        tbl_armed[NUM_FDS];
  logic [31:0] tbl_events[NUM_FDS];
  logic [63:0] tbl_data[NUM_FDS];
  logic [31:0] tbl_last_rev[NUM_FDS];
  logic [63:0] tbl_last_seq[NUM_FDS];
  logic [63:0] membership_changes;
  logic [15:0] delivered_in_round;
  logic [15:0] round_cap;

  int items_sent = 0;
  int items_taken = 0;
  int idle_pct = 0;
  int mismatches = 0;
  int deliveries = 0;
  int quiet_cycles = 0;
  int status_seen[8];
  eit_result_t want;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic eit_cmd_t mk(input logic [2:0] op, input logic [5:0] fd,
                                  input logic open, input logic [31:0] mask,
                                  input logic [63:0] data, input logic [31:0] rev,
                                  input logic hs, input logic [63:0] seq,
                                  input logic [15:0] maxev);
    eit_cmd_t c;
    c.op = op;
    c.fd = fd;
    c.fd_open = open;
    c.event_mask = mask;
    c.user_data = data;
    c.revents = rev;
    c.has_read_seq = hs;
    c.read_seq = seq;
    c.max_events = maxev;
    return c;
  endfunction

  task automatic queue_cmd(input eit_cmd_t c);
    cmd_backlog = {cmd_backlog, c};
  endtask

  task automatic apply_to_table(input eit_cmd_t c);
    eit_result_t r;
    logic [31:0] fire;
    logic        et_mode;
    logic [5:0]  i;
    r = '0;
    i = c.fd;
    case (c.op)
      OP_REPORT: begin
        if (!tbl_present[i] || !tbl_armed[i]) begin
          r.status = STATUS_NOT_ARMED;
        end else if (delivered_in_round >= round_cap) begin
          r.status = STATUS_FULL;
        end else begin
          r.status = STATUS_OK;
          et_mode = tbl_events[i][EV_EDGE_BIT];
          fire = et_mode ? (c.revents & ~tbl_last_rev[i]) : c.revents;
          if (et_mode && c.revents[EV_READ_BIT] && c.has_read_seq &&
              c.read_seq != tbl_last_seq[i])
            fire[EV_READ_BIT] = 1'b1;
          if (et_mode) begin
            tbl_last_rev[i] = c.revents;
            if (fire[EV_READ_BIT] && c.has_read_seq)
              tbl_last_seq[i] = c.read_seq;
          end
          if (fire != '0) begin
            r.report_valid = 1'b1;
            r.report_mask = fire;
            r.report_data = tbl_data[i];
            delivered_in_round = delivered_in_round + 16'd1;
            if (tbl_events[i][EV_ONESHOT_BIT])
              tbl_armed[i] = 1'b0;
          end
        end
      end
      OP_ROUND: begin
        round_cap = (c.max_events == '0) ? 16'd1 : c.max_events;
        delivered_in_round = '0;
      end
      default: begin
        if (!c.fd_open) begin
          r.status = STATUS_BAD_FD;
        end else begin
          case (c.op)
            OP_ADD: begin
              if (tbl_present[i]) begin
                r.status = STATUS_EXISTS;
              end else begin
                tbl_present[i] = 1'b1;
                tbl_armed[i] = 1'b1;
                tbl_events[i] = c.event_mask;
                tbl_data[i] = c.user_data;
                tbl_last_rev[i] = '0;
                tbl_last_seq[i] = '0;
                membership_changes = membership_changes + 64'd1;
              end
            end
            OP_DELETE: begin
              if (!tbl_present[i]) begin
                r.status = STATUS_NO_ENTRY;
              end else begin
                tbl_present[i] = 1'b0;
                tbl_armed[i] = 1'b0;
                membership_changes = membership_changes + 64'd1;
              end
            end
            OP_MODIFY: begin
              if (!tbl_present[i]) begin
                r.status = STATUS_NO_ENTRY;
              end else begin
                tbl_armed[i] = 1'b1;
                tbl_events[i] = c.event_mask;
                tbl_data[i] = c.user_data;
                tbl_last_rev[i] = '0;
                membership_changes = membership_changes + 64'd1;
              end
            end
            default: begin
              r.status = STATUS_INVALID;
            end
          endcase
        end
      end
    endcase
    r.change_count = membership_changes;
    pending_results = {pending_results, r};
  endtask

  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_to_table(cmd);
        items_taken++;
      end
      if (!start || !busy) begin
        case ((items_sent / PHASE_ITEMS) % 4)
          1: idle_pct = 48;
          3: idle_pct = 38;
          default: idle_pct = 0;
        endcase
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cmd <= cmd_backlog.pop_front();
          start <= 1'b1;
          items_sent++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, got %p", $time, result);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(result.status));
        check_field("report_valid", 64'(want.report_valid), 64'(result.report_valid));
        check_field("report_mask", 64'(want.report_mask), 64'(result.report_mask));
        check_field("report_data", want.report_data, result.report_data);
        check_field("change_count", want.change_count, result.change_count);
        status_seen[want.status]++;
        if (want.report_valid)
          deliveries++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  initial begin
    eit_cmd_t c;
    int roll;
    logic [3:0] pick;
    for (int k = 0; k < NUM_FDS; k++) begin
      tbl_present[k] = 1'b0;
      tbl_armed[k] = 1'b0;
      tbl_events[k] = '0;
      tbl_data[k] = '0;
      tbl_last_rev[k] = '0;
      tbl_last_seq[k] = '0;
    end
    for (int k = 0; k < 8; k++)
      status_seen[k] = 0;
    membership_changes = '0;
    delivered_in_round = '0;
    round_cap = 16'd1;

    queue_cmd(mk(OP_ROUND, 6'd0, 1'b1, '0, '0, '0, 1'b0, '0, 16'hFFFF));
    queue_cmd(mk(OP_ADD, 6'd0, 1'b1, ET_FLAG | READ_FLAG,
                 64'h0123_4567_89AB_CDEF, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_ADD, 6'd0, 1'b1, '0, '0, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_ADD, 6'd5, 1'b0, '0, '0, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_DELETE, 6'd9, 1'b1, '0, '0, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_MODIFY, 6'd9, 1'b1, '0, '0, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_UNDEF_LO, 6'd1, 1'b1, '0, '0, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_UNDEF_HI, 6'd1, 1'b0, '0, '0, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_REPORT, 6'd9, 1'b1, '0, '0, READ_FLAG, 1'b1, 64'd5, '0));
    queue_cmd(mk(OP_REPORT, 6'd0, 1'b0, '0, '0, READ_FLAG, 1'b1, 64'd5, '0));
    queue_cmd(mk(OP_REPORT, 6'd0, 1'b1, '0, '0, READ_FLAG, 1'b1, 64'd5, '0));
    queue_cmd(mk(OP_REPORT, 6'd0, 1'b1, '0, '0, READ_FLAG, 1'b1, 64'd6, '0));
    queue_cmd(mk(OP_REPORT, 6'd0, 1'b1, '0, '0, 32'h3, 1'b0, 64'd6, '0));
    queue_cmd(mk(OP_ADD, 6'd63, 1'b1, ONESHOT_FLAG, '1, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_REPORT, 6'd63, 1'b1, '0, '0, '1, 1'b1, '1, '0));
    queue_cmd(mk(OP_REPORT, 6'd63, 1'b1, '0, '0, READ_FLAG, 1'b0, '0, '0));
    queue_cmd(mk(OP_MODIFY, 6'd63, 1'b1, '1, '0, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_REPORT, 6'd63, 1'b1, '0, '0, '0, 1'b1, '0, '0));
    queue_cmd(mk(OP_ROUND, 6'd0, 1'b1, '0, '0, '0, 1'b0, '0, 16'd0));
    queue_cmd(mk(OP_REPORT, 6'd63, 1'b1, '0, '0, 32'h2, 1'b1, '0, '0));
    queue_cmd(mk(OP_REPORT, 6'd0, 1'b1, '0, '0, 32'h4, 1'b0, '0, '0));
    queue_cmd(mk(OP_DELETE, 6'd63, 1'b1, '0, '0, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_DELETE, 6'd0, 1'b1, '0, '0, '0, 1'b0, '0, '0));
    queue_cmd(mk(OP_ROUND, 6'd0, 1'b1, '0, '0, '0, 1'b0, '0, 16'd8));

    // Most commands hit a small pool of descriptors at both ends of the table so
    // that adds, reports and deletes keep meeting live entries.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      roll = $urandom_range(99);
      pick = 4'($urandom_range(15));
      if (roll < 45)
        c.op = OP_REPORT;
      else if (roll < 62)
        c.op = OP_ADD;
      else if (roll < 72)
        c.op = OP_MODIFY;
      else if (roll < 82)
        c.op = OP_DELETE;
      else if (roll < 94)
        c.op = OP_ROUND;
      else
        c.op = 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
      c.fd = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : {{3{pick[3]}}, pick[2:0]};
      c.fd_open = ($urandom_range(11) != 0);
      c.event_mask = {($urandom_range(1) == 1), ($urandom_range(9) < 3), 30'($urandom)};
      c.user_data = {$urandom, $urandom};
      if ($urandom_range(6) == 0) begin
        c.revents = $urandom;
        c.read_seq = {$urandom, $urandom};
      end else begin
        c.revents = 32'($urandom_range(15));
        c.read_seq = 64'($urandom_range(3));
      end
      c.has_read_seq = ($urandom_range(1) == 1);
      case ($urandom_range(9))
        0: c.max_events = '0;
        1: c.max_events = '1;
        2: c.max_events = 16'($urandom);
        default: c.max_events = 16'($urandom_range(12, 1));
      endcase
      queue_cmd(c);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do
      @(negedge clk);
    while (cmd_backlog.size() != 0 || start || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items over four pacing phases: %0d events delivered, %0d reports refused",
             items_taken, deliveries, status_seen[STATUS_FULL]);
    $display("for a full round, %0d on disarmed entries, %0d membership errors.",
             status_seen[STATUS_NOT_ARMED], status_seen[STATUS_BAD_FD] +
             status_seen[STATUS_EXISTS] + status_seen[STATUS_NO_ENTRY] +
             status_seen[STATUS_INVALID]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/eit_pkg.sv
hdl/eit_flag_mem.sv
hdl/eit_entry_mem.sv
hdl/eit_exec.sv
hdl/event_interest_table.sv
tb/tb_event_interest_table.sv
